FILE: rtl/lmsc_pkg.sv
// Shared constants and the row summary type of the min-sum check-node update.
`default_nettype none

package lmsc_pkg;

	// Row geometry and message format.
	localparam int MAX_DEGREE = 32;
	localparam int MSG_WIDTH  = 8;
	localparam int MAG_W      = MSG_WIDTH - 1;
	localparam int POS_W      = $clog2(MAX_DEGREE);
	localparam int CNT_W      = $clog2(MAX_DEGREE + 1);

	// Largest magnitude; also the reset value of both minima.
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	// Summary of one finished row, handed from the front end to the back end.
	typedef struct packed {
		logic [MAX_DEGREE-1:0] signs;
		logic [MAG_W-1:0]      min_first;
		logic [MAG_W-1:0]      min_second;
		logic [POS_W-1:0]      min_position;
		logic                  parity;
		logic [CNT_W-1:0]      count;
		logic                  overflow;
	} row_t;

endpackage

`default_nettype wire

FILE: rtl/lmsc_front.sv
// Front end: accepts messages and builds the per-row minimum and sign summary.
`default_nettype none

module lmsc_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	input  wire logic signed [lmsc_pkg::MSG_WIDTH-1:0] v2c_msg,
	input  wire logic                                 last_msg,
	input  wire logic                                 q_full,
	output logic                                      q_push,
	output lmsc_pkg::row_t                            q_row
);

	logic                              accept;
	logic                              neg;
	logic [lmsc_pkg::MSG_WIDTH-1:0]    neg_raw;
	logic [lmsc_pkg::MAG_W-1:0]        mag;
	logic                              room;

	logic [lmsc_pkg::MAX_DEGREE-1:0]   signs_q;
	logic [lmsc_pkg::MAG_W-1:0]        min_first_q;
	logic [lmsc_pkg::MAG_W-1:0]        min_second_q;
	logic [lmsc_pkg::POS_W-1:0]        min_position_q;
	logic                              parity_q;
	logic [lmsc_pkg::CNT_W-1:0]        count_q;
	logic                              overflow_q;

	lmsc_pkg::row_t                    row_d;

	assign accept = push && !q_full;

	// Sign and magnitude of the incoming message; the most negative code clamps.
	always_comb begin
		neg     = v2c_msg[lmsc_pkg::MSG_WIDTH-1];
		neg_raw = (~v2c_msg) + 1'b1;
		if (!neg) begin
			mag = v2c_msg[lmsc_pkg::MAG_W-1:0];
		end else if (neg_raw[lmsc_pkg::MSG_WIDTH-1]) begin
			mag = lmsc_pkg::MAG_MAX;
		end else begin
			mag = neg_raw[lmsc_pkg::MAG_W-1:0];
		end
	end

	assign room = count_q < lmsc_pkg::CNT_W'(lmsc_pkg::MAX_DEGREE);

	// Row summary after folding in the current message.
	always_comb begin
		row_d.signs        = signs_q;
		row_d.min_first    = min_first_q;
		row_d.min_second   = min_second_q;
		row_d.min_position = min_position_q;
		row_d.parity       = parity_q;
		row_d.count        = count_q;
		row_d.overflow     = overflow_q;
		if (room) begin
			row_d.signs[count_q[lmsc_pkg::POS_W-1:0]] = neg;
			row_d.parity = parity_q ^ neg;
			if (mag < min_first_q) begin
				row_d.min_second   = min_first_q;
				row_d.min_first    = mag;
				row_d.min_position = count_q[lmsc_pkg::POS_W-1:0];
			end else if (mag < min_second_q) begin
				row_d.min_second = mag;
			end
			row_d.count = count_q + 1'b1;
		end else begin
			row_d.overflow = 1'b1;
		end
	end

	assign q_push = accept && last_msg;
	assign q_row  = row_d;

	// Row state; it returns to its start values once a row is handed over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_first_q    <= lmsc_pkg::MAG_MAX;
			min_second_q   <= lmsc_pkg::MAG_MAX;
			min_position_q <= '0;
			parity_q       <= 1'b0;
			count_q        <= '0;
			overflow_q     <= 1'b0;
		end else if (accept) begin
			if (last_msg) begin
				min_first_q    <= lmsc_pkg::MAG_MAX;
				min_second_q   <= lmsc_pkg::MAG_MAX;
				min_position_q <= '0;
				parity_q       <= 1'b0;
				count_q        <= '0;
				overflow_q     <= 1'b0;
			end else begin
				min_first_q    <= row_d.min_first;
				min_second_q   <= row_d.min_second;
				min_position_q <= row_d.min_position;
				parity_q       <= row_d.parity;
				count_q        <= row_d.count;
				overflow_q     <= row_d.overflow;
			end
		end
	end

	// Sign bits need no reset: only entries written in the current row are read.
	always_ff @(posedge clk) begin
		if (accept) begin
			signs_q <= row_d.signs;
		end
	end

`ifndef SYNTHESIS
	a_min_order: assert property (@(posedge clk) disable iff (!arst_n)
		min_first_q <= min_second_q)
		else $error("front: first minimum exceeds second minimum");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lmsc_pkg::CNT_W'(lmsc_pkg::MAX_DEGREE))
		else $error("front: message count beyond row capacity");
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> count_q == lmsc_pkg::CNT_W'(lmsc_pkg::MAX_DEGREE))
		else $error("front: overflow flagged on a row that is not full");
`endif

endmodule

`default_nettype wire

FILE: rtl/lmsc_queue.sv
// Two-entry queue of row summaries between the front end and the back end.
`default_nettype none

module lmsc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire lmsc_pkg::row_t wr_row,
	output logic                full,
	input  wire logic           rd_en,
	output logic                rd_valid,
	output lmsc_pkg::row_t      rd_row
);

	lmsc_pkg::row_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;

	assign full     = fill_q == 2'd2;
	assign rd_valid = fill_q != 2'd0;
	assign rd_row   = entry_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_row;
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'd2)
		else $error("queue: fill level out of range");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("queue: write into a full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("queue: read from an empty queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/lmsc_back.sv
// Back end: walks a row summary and emits one check-to-variable message per position.
`default_nettype none

module lmsc_back (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  row_valid,
	input  wire lmsc_pkg::row_t                        row,
	output logic                                       row_done,
	input  wire logic                                  pop,
	output logic                                       empty,
	output logic signed [lmsc_pkg::MSG_WIDTH-1:0]      c2v_msg,
	output logic [lmsc_pkg::POS_W-1:0]                 position,
	output logic                                       last_out,
	output logic                                       overflow
);

	logic [lmsc_pkg::POS_W-1:0]     k_q;
	logic                           out_valid_q;
	logic [lmsc_pkg::MSG_WIDTH-1:0] msg_q;
	logic [lmsc_pkg::POS_W-1:0]     pos_q;
	logic                           last_q;
	logic                           ovf_q;

	logic                           advance;
	logic                           is_last;
	logic [lmsc_pkg::MAG_W-1:0]     mag;
	logic                           sgn;
	logic [lmsc_pkg::MSG_WIDTH-1:0] mag_ext;
	logic [lmsc_pkg::MSG_WIDTH-1:0] value;

	assign advance  = row_valid && (!out_valid_q || pop);
	assign is_last  = ({1'b0, k_q} + 1'b1) == row.count;
	assign row_done = advance && is_last;

	// Output value for the current position; a zero magnitude stays zero.
	always_comb begin
		mag     = (k_q == row.min_position) ? row.min_second : row.min_first;
		sgn     = row.parity ^ row.signs[k_q];
		mag_ext = {1'b0, mag};
		value   = sgn ? ((~mag_ext) + 1'b1) : mag_ext;
	end

	// Position counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				k_q         <= is_last ? '0 : k_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (advance) begin
			msg_q  <= value;
			pos_q  <= k_q;
			last_q <= is_last;
			ovf_q  <= row.overflow;
		end
	end

	assign empty    = !out_valid_q;
	assign c2v_msg  = msg_q;
	assign position = pos_q;
	assign last_out = last_q;
	assign overflow = ovf_q;

`ifndef SYNTHESIS
	a_pos_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> {1'b0, k_q} < row.count)
		else $error("back: position counter beyond row length");
	a_row_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> row.count != '0)
		else $error("back: row summary with no messages");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		row_done |=> k_q == '0)
		else $error("back: position counter not cleared after a row");
`endif

endmodule

`default_nettype wire

FILE: rtl/ldpc_min_sum_check_node.sv
// A row's first result goes through a queue entry and the output register after its
// last message is accepted, or later while the back end still emits earlier rows.
// Throughput: one message per cycle unless full; one result per cycle while popped.
// A row summary passes through a two-entry queue, so the back end can emit one row
// while the front end gathers the next; full rises only while both entries wait.
// Reset clears the row state, the queue and the output valid; sign bits are not reset.
`default_nettype none

module ldpc_min_sum_check_node (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	output logic                                       full,
	input  wire logic signed [lmsc_pkg::MSG_WIDTH-1:0] v2c_msg,
	input  wire logic                                  last_msg,
	output logic                                       empty,
	input  wire logic                                  pop,
	output logic signed [lmsc_pkg::MSG_WIDTH-1:0]      c2v_msg,
	output logic [lmsc_pkg::POS_W-1:0]                 position,
	output logic                                       last_out,
	output logic                                       overflow
);

	logic           q_full;
	logic           q_push;
	lmsc_pkg::row_t q_wr_row;
	logic           q_valid;
	lmsc_pkg::row_t q_rd_row;
	logic           q_pop;

	assign full = q_full;

	// Message intake and row summary.
	lmsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.v2c_msg  (v2c_msg),
		.last_msg (last_msg),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_row    (q_wr_row)
	);

	// Finished rows waiting for output.
	lmsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_row   (q_wr_row),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_row   (q_rd_row)
	);

	// Result generation.
	lmsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (q_valid),
		.row       (q_rd_row),
		.row_done  (q_pop),
		.pop       (pop),
		.empty     (empty),
		.c2v_msg   (c2v_msg),
		.position  (position),
		.last_out  (last_out),
		.overflow  (overflow)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the min-sum check-node update block.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// One variable-to-check message waiting to be sent, with its traffic settings.
	typedef struct {
		logic signed [lmsc_pkg::MSG_WIDTH-1:0] value;
		logic                                  is_last;
		int                                    phase;
		logic                                  drain;
	} v2c_item_t;

	// One check-to-variable message as the block should deliver it.
	typedef struct packed {
		logic signed [lmsc_pkg::MSG_WIDTH-1:0] c2v;
		logic [lmsc_pkg::POS_W-1:0]            pos;
		logic                                  is_last;
		logic                                  ovf;
	} c2v_item_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 20;

	// Percent of cycles in which the sender idles and the receiver stalls, per phase.
	int send_idle_pct [4] = '{0, 52, 0, 13};
	int recv_stall_pct[4] = '{0, 0, 52, 13};

	logic                                   clk;
	logic                                   arst_n   = 1'b0;
	logic                                   push     = 1'b0;
	logic                                   pop      = 1'b0;
	logic signed [lmsc_pkg::MSG_WIDTH-1:0]  v2c_msg  = '0;
	logic                                   last_msg = 1'b0;
	logic                                   full;
	logic                                   empty;
	logic signed [lmsc_pkg::MSG_WIDTH-1:0]  c2v_msg;
	logic [lmsc_pkg::POS_W-1:0]             position;
	logic                                   last_out;
	logic                                   overflow;

	v2c_item_t msg_q[$];
	c2v_item_t c2v_q[$];

	// Predicted row state.
	logic [lmsc_pkg::MAG_W-1:0] row_min1    = lmsc_pkg::MAG_MAX;
	logic [lmsc_pkg::MAG_W-1:0] row_min2    = lmsc_pkg::MAG_MAX;
	logic [lmsc_pkg::POS_W-1:0] row_min_pos = '0;
	logic                       row_parity  = 1'b0;
	logic                       row_ovf     = 1'b0;
	int                         row_count   = 0;
	logic                       row_signs[lmsc_pkg::MAX_DEGREE];

	int cur_phase    = 0;
	int errors       = 0;
	int msgs_sent    = 0;
	int rows_sent    = 0;
	int long_rows    = 0;
	int results_seen = 0;
	int idle_cycles  = 0;

	ldpc_min_sum_check_node dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.v2c_msg  (v2c_msg),
		.last_msg (last_msg),
		.empty    (empty),
		.pop      (pop),
		.c2v_msg  (c2v_msg),
		.position (position),
		.last_out (last_out),
		.overflow (overflow)
	);

	// Free-running 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Fold one accepted message into the row; at the row end, queue the row's outputs.
	task automatic fold_message(input logic signed [lmsc_pkg::MSG_WIDTH-1:0] msg,
			input logic is_last);
		logic                             neg;
		logic [lmsc_pkg::MSG_WIDTH-1:0]   mag_full;
		logic [lmsc_pkg::MAG_W-1:0]       mag;
		logic [lmsc_pkg::MAG_W-1:0]       m;
		logic                             s;
		c2v_item_t                        r;
		int                               k;
		neg = msg[lmsc_pkg::MSG_WIDTH-1];
		mag_full = neg ? (~msg + 1'b1) : msg;
		mag = (mag_full > lmsc_pkg::MSG_WIDTH'(lmsc_pkg::MAG_MAX)) ? lmsc_pkg::MAG_MAX :
			mag_full[lmsc_pkg::MAG_W-1:0];
		if (row_count < lmsc_pkg::MAX_DEGREE) begin
			row_signs[row_count] = neg;
			row_parity ^= neg;
			// A tie with the minimum lands in the second minimum.
			if (mag < row_min1) begin
				row_min2 = row_min1;
				row_min1 = mag;
				row_min_pos = lmsc_pkg::POS_W'(row_count);
			end else if (mag < row_min2) begin
				row_min2 = mag;
			end
			row_count++;
		end else begin
			row_ovf = 1'b1;
		end
		if (is_last) begin
			for (k = 0; k < row_count; k++) begin
				m = (k == row_min_pos) ? row_min2 : row_min1;
				s = row_parity ^ row_signs[k];
				r.c2v = s ? (~{1'b0, m} + 1'b1) : {1'b0, m};
				r.pos = lmsc_pkg::POS_W'(k);
				r.is_last = (k + 1 == row_count);
				r.ovf = row_ovf;
				c2v_q.push_back(r);
			end
			rows_sent++;
			if (row_ovf)
				long_rows++;
			row_min1 = lmsc_pkg::MAG_MAX;
			row_min2 = lmsc_pkg::MAG_MAX;
			row_min_pos = '0;
			row_parity = 1'b0;
			row_ovf = 1'b0;
			row_count = 0;
		end
	endtask

	function automatic void add_msg(input int value, input logic is_last, input int phase,
			input logic drain);
		v2c_item_t it;
		it.value = lmsc_pkg::MSG_WIDTH'(value);
		it.is_last = is_last;
		it.phase = phase;
		it.drain = drain;
		msg_q.push_back(it);
	endfunction

	// Random LLR: full range, small values that force ties and zeros, or an extreme.
	function automatic int rand_llr();
		int sel;
		int extremes[6] = '{-128, 127, -127, 0, 1, -1};
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return $signed(lmsc_pkg::MSG_WIDTH'($urandom()));
		else if (sel < 8)
			return $urandom_range(0, 12) - 6;
		else
			return extremes[$urandom_range(0, 5)];
	endfunction

	// Driver: retire the accepted transaction, then offer the next message or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			v2c_msg <= '0;
			last_msg <= 1'b0;
		end else begin
			if (push && !full) begin
				fold_message(v2c_msg, last_msg);
				void'(msg_q.pop_front());
				msgs_sent++;
			end
			if (push && full) begin
				// Keep offering the same message until it is taken.
			end else if (msg_q.size() > 0 && (!msg_q[0].drain || c2v_q.size() == 0) &&
					$urandom_range(0, 99) >= send_idle_pct[msg_q[0].phase]) begin
				push <= 1'b1;
				v2c_msg <= msg_q[0].value;
				last_msg <= msg_q[0].is_last;
				cur_phase <= msg_q[0].phase;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure and an in-order check of every result transaction.
	always @(posedge clk or negedge arst_n) begin
		c2v_item_t got;
		c2v_item_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				got = '{c2v_msg, position, last_out, overflow};
				results_seen++;
				if (c2v_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result c2v=%0d pos=%0d last=%0b ovf=%0b",
						$time, got.c2v, got.pos, got.is_last, got.ovf);
				end else begin
					want = c2v_q.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected c2v=%0d pos=%0d last=%0b ovf=%0b",
							$time, want.c2v, want.pos, want.is_last, want.ovf);
						$display("%0t:          actual   c2v=%0d pos=%0d last=%0b ovf=%0b",
							$time, got.c2v, got.pos, got.is_last, got.ovf);
					end
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_stall_pct[cur_phase]);
		end
	end

	// Watchdog: end the run if no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("ldpc_min_sum_check_node verification failed");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of test.
	initial begin
		int n_rand;
		int phase;
		int prev_phase;
		int len;
		int i;
		logic drain;

		// Directed rows: single-message rows, the most negative value next to zero,
		// negative zero from a tie at zero, a tie with the minimum, and the extremes.
		add_msg(5, 1'b1, 0, 1'b0);
		add_msg(-5, 1'b1, 0, 1'b0);
		add_msg(-128, 1'b1, 0, 1'b0);
		add_msg(-128, 1'b0, 0, 1'b0);
		add_msg(0, 1'b1, 0, 1'b0);
		add_msg(0, 1'b0, 0, 1'b0);
		add_msg(0, 1'b0, 0, 1'b0);
		add_msg(-4, 1'b1, 0, 1'b0);
		add_msg(10, 1'b0, 0, 1'b1);
		add_msg(-10, 1'b0, 0, 1'b0);
		add_msg(20, 1'b1, 0, 1'b0);
		add_msg(127, 1'b0, 0, 1'b0);
		add_msg(-127, 1'b0, 0, 1'b0);
		add_msg(-1, 1'b0, 0, 1'b0);
		add_msg(1, 1'b0, 0, 1'b0);
		add_msg(-128, 1'b1, 0, 1'b0);
		add_msg(-3, 1'b0, 0, 1'b0);
		add_msg(-7, 1'b0, 0, 1'b0);
		add_msg(-3, 1'b0, 0, 1'b0);
		add_msg(85, 1'b0, 0, 1'b0);
		add_msg(-86, 1'b1, 0, 1'b0);

		// Random rows across the four traffic phases; each phase opens on a full row
		// or an over-length one and after a drain of all pending results.
		n_rand = 0;
		prev_phase = 0;
		while (n_rand < 360) begin
			phase = (n_rand * 4) / 360;
			if (phase > 3)
				phase = 3;
			drain = ($urandom_range(0, 5) == 0);
			len = $urandom_range(0, 19);
			if (n_rand == 0 || (phase != prev_phase && phase % 2 == 0)) begin
				len = lmsc_pkg::MAX_DEGREE + 1;
				drain = 1'b1;
			end else if (phase != prev_phase) begin
				len = lmsc_pkg::MAX_DEGREE;
				drain = 1'b1;
			end else if (len < 12) begin
				len = $urandom_range(1, 6);
			end else if (len < 17) begin
				len = $urandom_range(7, lmsc_pkg::MAX_DEGREE - 1);
			end else if (len == 17) begin
				len = lmsc_pkg::MAX_DEGREE;
			end else begin
				len = $urandom_range(lmsc_pkg::MAX_DEGREE + 1, lmsc_pkg::MAX_DEGREE + 8);
			end
			for (i = 0; i < len; i++)
				add_msg(rand_llr(), i == len - 1, phase, drain && i == 0);
			n_rand += len;
			prev_phase = phase;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (msg_q.size() != 0 || c2v_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d messages in %0d rows, %0d of them over-length.",
			msgs_sent, rows_sent, long_rows);
		$display("Checked %0d check-to-variable results under four traffic phases.",
			results_seen);
		if (errors == 0) begin
			$display("ldpc_min_sum_check_node verification clean");
		end else begin
			$display("ldpc_min_sum_check_node verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/lmsc_pkg.sv
rtl/lmsc_front.sv
rtl/lmsc_queue.sv
rtl/lmsc_back.sv
rtl/ldpc_min_sum_check_node.sv
tb/testbench.sv
